>>> src/fir16_pkg.sv
// Shared constants, types and the output clamp for the 16-tap FIR filter.
// No dependencies; every other file of the block refers to this package.
package fir16_pkg;

   localparam int TAPS         = 16;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEFF_WIDTH  = 16;
   localparam int OUT_WIDTH    = 36;

   localparam int COEFF_WORDS  = 4;
   localparam int CSR_WORD_W   = 64;
   localparam int CSR_INDEX_W  = 8;
   localparam int COEFF_IDX_W  = $clog2(COEFF_WORDS);

   localparam int FILL_W       = $clog2(TAPS);
   localparam int LEVELS       = $clog2(TAPS);
   localparam int TREE_N       = 1 << LEVELS;

   localparam int PROD_W       = SAMPLE_WIDTH + COEFF_WIDTH;
   localparam int SUM_W        = (PROD_W + LEVELS > OUT_WIDTH) ? PROD_W + LEVELS : OUT_WIDTH;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEFF_WIDTH-1:0]  coeff_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [SUM_W-1:0]        sum_type;
   typedef logic signed [OUT_WIDTH-1:0]    out_type;
   typedef logic [CSR_WORD_W-1:0]          csr_word_type;
   typedef logic [CSR_INDEX_W-1:0]         csr_index_type;

   // Pipeline control handed from the top level to the adder tree
   typedef struct packed {
      logic advance;
      logic valid;
      logic last;
   } stage_ctl_type;

   localparam sum_type OUT_MAX = sum_type'((65'sd1 <<< (OUT_WIDTH - 1)) - 65'sd1);
   localparam sum_type OUT_MIN = sum_type'(-(65'sd1 <<< (OUT_WIDTH - 1)));

   // Saturate a full sum to the output range
   function automatic out_type sat_out(input sum_type v);
      out_type r;
      if (v > OUT_MAX) begin
         r = out_type'(OUT_MAX);
      end else if (v < OUT_MIN) begin
         r = out_type'(OUT_MIN);
      end else begin
         r = out_type'(v);
      end
      return r;
   endfunction

endpackage

>>> src/fir16_ifs.sv
// Valid/ready channel interfaces: sample input, filtered result, register writes.
// Payload types come from fir16_pkg.
interface fir16_req_if;
   logic                  valid;
   logic                  ready;
   fir16_pkg::sample_type sample;
   logic                  block_start;
   logic                  block_end;

   modport source (output valid, output sample, output block_start, output block_end,
                   input ready);
   modport sink   (input valid, input sample, input block_start, input block_end,
                   output ready);
endinterface

interface fir16_rsp_if;
   logic               valid;
   logic               ready;
   fir16_pkg::out_type filtered;
   logic               last;

   modport source (output valid, output filtered, output last, input ready);
   modport sink   (input valid, input filtered, input last, output ready);
endinterface

interface fir16_csr_if;
   logic                     valid;
   logic                     ready;
   fir16_pkg::csr_index_type index;
   fir16_pkg::csr_word_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/fir_filter_16_tap.sv
// Streaming 16-tap FIR filter (valid mode), top level.
// Throughput: one sample per cycle when no result stalls; the whole tap row and tree
//   advance together. The product row is registered when its sample is accepted,
//   then four adder-tree levels follow; a stalled result stalls the input.
// Reset (synchronous): history, fill count and coefficients clear; pipeline empties.
// Depends on fir16_pkg, fir16_ifs, fir16_tap_cell and fir16_adder_tree.
module fir_filter_16_tap (
   input  logic        clock,
   input  logic        reset,
   fir16_req_if.sink   req_ch,
   fir16_rsp_if.source rsp_ch,
   fir16_csr_if.sink   csr_ch
);

   localparam logic [fir16_pkg::FILL_W-1:0] FILL_MAX = fir16_pkg::FILL_W'(fir16_pkg::TAPS - 1);

   fir16_pkg::csr_word_type coeff_ff [fir16_pkg::COEFF_WORDS];
   logic [fir16_pkg::COEFF_WORDS*fir16_pkg::CSR_WORD_W-1:0] coeff_bank;

   logic [fir16_pkg::FILL_W-1:0] fill_ff;
   logic [fir16_pkg::FILL_W-1:0] fill_in;
   logic [fir16_pkg::FILL_W-1:0] fill_eff;

   logic advance;
   logic accept;
   logic produce;

   fir16_pkg::sample_type    taps     [fir16_pkg::TAPS+1];
   fir16_pkg::prod_type      products [fir16_pkg::TAPS];
   fir16_pkg::stage_ctl_type ctl;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < fir16_pkg::COEFF_WORDS; w++) begin
            coeff_ff[w] <= '0;
         end
      end else if (csr_ch.valid &&
                   (csr_ch.index < fir16_pkg::CSR_INDEX_W'(fir16_pkg::COEFF_WORDS))) begin
         coeff_ff[csr_ch.index[fir16_pkg::COEFF_IDX_W-1:0]] <= csr_ch.data;
      end
   end

   always_comb begin
      for (int w = 0; w < fir16_pkg::COEFF_WORDS; w++) begin
         coeff_bank[w*fir16_pkg::CSR_WORD_W +: fir16_pkg::CSR_WORD_W] = coeff_ff[w];
      end
   end

   // Handshake: everything moves when the output register is free
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // Fill count: a start flag restarts the block before this sample counts
   assign fill_eff = req_ch.block_start ? '0 : fill_ff;
   assign produce  = (fill_eff == FILL_MAX);
   assign fill_in  = (fill_eff == FILL_MAX) ? fill_eff : fill_eff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   // Row of tap cells: cell j sees x[n-j] and keeps it as the next cell's input
   assign taps[0] = req_ch.sample;

   for (genvar j = 0; j < fir16_pkg::TAPS; j++) begin : g_cell
      fir16_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (accept),
         .load       (advance),
         .sample_in  (taps[j]),
         .coeff      (fir16_pkg::coeff_type'(coeff_bank[j*fir16_pkg::COEFF_WIDTH +:
                                                        fir16_pkg::COEFF_WIDTH])),
         .sample_out (taps[j+1]),
         .product    (products[j])
      );
   end

   assign ctl.advance = advance;
   assign ctl.valid   = accept && produce;
   assign ctl.last    = req_ch.block_end;

   fir16_adder_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .products  (products),
      .sum       (rsp_ch.filtered),
      .sum_valid (rsp_ch.valid),
      .sum_last  (rsp_ch.last)
   );

   a_start_restarts_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.block_start) |=> (fill_ff == fir16_pkg::FILL_W'(1)))
      else $error("block start did not restart the fill count");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while the result is stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (fill_ff == '0 && !rsp_ch.valid))
      else $error("reset left fill count or result pending");

endmodule

>>> src/fir16_tap_cell.sv
// One tap of the delay line: holds one history sample and registers its product.
// Uses fir16_pkg types; instantiated in a row by fir_filter_16_tap.
module fir16_tap_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic                  load,
   input  fir16_pkg::sample_type sample_in,
   input  fir16_pkg::coeff_type  coeff,
   output fir16_pkg::sample_type sample_out,
   output fir16_pkg::prod_type   product
);

   fir16_pkg::sample_type tap_ff;
   fir16_pkg::prod_type   prod_ff;
   fir16_pkg::prod_type   prod_in;

   assign prod_in = fir16_pkg::prod_type'(sample_in) * fir16_pkg::prod_type'(coeff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else if (shift) begin
         tap_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign sample_out = tap_ff;
   assign product    = prod_ff;

endmodule

>>> src/fir16_adder_tree.sv
// Registered binary adder tree over the tap products, with valid/last tracking
// and output saturation. Uses fir16_pkg.
module fir16_adder_tree (
   input  logic                     clock,
   input  logic                     reset,
   input  fir16_pkg::stage_ctl_type ctl,
   input  fir16_pkg::prod_type      products [fir16_pkg::TAPS],
   output fir16_pkg::out_type       sum,
   output logic                     sum_valid,
   output logic                     sum_last
);

   localparam int NODES = fir16_pkg::TREE_N - 1;

   fir16_pkg::sum_type leaf    [fir16_pkg::TREE_N];
   fir16_pkg::sum_type node_ff [NODES];
   fir16_pkg::sum_type node_in [NODES];

   logic [fir16_pkg::LEVELS:0] vld_ff;
   logic [fir16_pkg::LEVELS:0] last_ff;

   // Pad the leaf row to a power of two with zeros
   for (genvar i = 0; i < fir16_pkg::TREE_N; i++) begin : g_leaf
      if (i < fir16_pkg::TAPS) begin : g_used
         assign leaf[i] = fir16_pkg::sum_type'(products[i]);
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // Heap order: node k adds children 2k+1 and 2k+2; the last row reads leaves
   for (genvar k = 0; k < NODES; k++) begin : g_node
      localparam int LEFT  = 2 * k + 1;
      localparam int RIGHT = 2 * k + 2;
      if (LEFT >= NODES) begin : g_from_leaf
         assign node_in[k] = leaf[LEFT - NODES] + leaf[RIGHT - NODES];
      end else begin : g_from_node
         assign node_in[k] = node_ff[LEFT] + node_ff[RIGHT];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int k = 0; k < NODES; k++) begin
            node_ff[k] <= node_in[k];
         end
         last_ff <= {last_ff[fir16_pkg::LEVELS-1:0], ctl.last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[fir16_pkg::LEVELS-1:0], ctl.valid};
      end
   end

   assign sum       = fir16_pkg::sat_out(node_ff[0]);
   assign sum_valid = vld_ff[fir16_pkg::LEVELS];
   assign sum_last  = last_ff[fir16_pkg::LEVELS];

endmodule

>>> test/tb_fir_filter_16_tap.sv
// Testbench for fir_filter_16_tap: streams samples, checks each filtered result against an
// in-bench 16-tap direct-form model. Depends on fir16_pkg, fir16_ifs and the RTL top level.
module tb_fir_filter_16_tap;

   localparam int RESULT_LATENCY = 5;
   localparam int DRAIN_CYCLES   = 3 * RESULT_LATENCY;
   localparam int IDLE_PERCENT   = 9;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int LIMIT_TIME     = 400000;

   localparam fir16_pkg::csr_index_type COEFF_WORD_0 = 0;
   localparam fir16_pkg::csr_index_type COEFF_WORD_1 = 1;
   localparam fir16_pkg::csr_index_type COEFF_WORD_2 = 2;
   localparam fir16_pkg::csr_index_type COEFF_WORD_3 = 3;

   localparam fir16_pkg::csr_word_type TAPS_ALL_MIN  = 64'h8000_8000_8000_8000;
   localparam fir16_pkg::csr_word_type TAPS_ALL_MAX  = 64'h7FFF_7FFF_7FFF_7FFF;
   localparam fir16_pkg::csr_word_type TAPS_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      fir16_pkg::out_type filtered;
      logic               last;
   } filter_out_type;

   logic clock;
   logic reset;

   fir16_req_if req_ch ();
   fir16_rsp_if rsp_ch ();
   fir16_csr_if csr_ch ();

   fir_filter_16_tap dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Filter state as the block should hold it
   fir16_pkg::csr_word_type tap_words [fir16_pkg::COEFF_WORDS];
   fir16_pkg::sample_type   past_samples [fir16_pkg::TAPS-1];
   int                      fill_level;

   filter_out_type expected_outputs [$];
   int             mismatch_count;
   bit             req_idle_on;
   bit             rsp_idle_on;
   int             hold_request;
   int             hold_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(LIMIT_TIME);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint tap_value(input int j);
      fir16_pkg::coeff_type c;
      c = tap_words[j / 4][16 * (j % 4) +: 16];
      return longint'(c);
   endfunction

   function automatic void predict_fir_output(input fir16_pkg::sample_type x, input logic st,
                                              input logic en);
      longint         acc;
      longint         sat_hi;
      filter_out_type r;
      sat_hi = (longint'(1) <<< (fir16_pkg::OUT_WIDTH - 1)) - 1;
      if (st) begin
         fill_level = 0;
      end
      if (fill_level >= fir16_pkg::TAPS - 1) begin
         acc = tap_value(0) * longint'(x);
         for (int j = 1; j < fir16_pkg::TAPS; j++) begin
            acc += tap_value(j) * longint'(past_samples[j-1]);
         end
         if (acc > sat_hi) begin
            acc = sat_hi;
         end else if (acc < -sat_hi - 1) begin
            acc = -sat_hi - 1;
         end
         r.filtered = acc[fir16_pkg::OUT_WIDTH-1:0];
         r.last     = en;
         expected_outputs.push_back(r);
      end
      for (int j = fir16_pkg::TAPS - 2; j > 0; j--) begin
         past_samples[j] = past_samples[j-1];
      end
      past_samples[0] = x;
      if (fill_level < fir16_pkg::TAPS - 1) begin
         fill_level++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_fir_output(req_ch.sample, req_ch.block_start, req_ch.block_end);
      end
   end

   always @(posedge clock) begin
      filter_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result: filtered=%0d last=%0b",
                        rsp_ch.filtered, rsp_ch.last);
            end
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_ch.filtered !== want.filtered || rsp_ch.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: expected filtered=%0d last=%0b, got filtered=%0d last=%0b",
                           want.filtered, want.last, rsp_ch.filtered, rsp_ch.last);
               end
            end
         end
      end
   end

   // Result side: random idle cycles, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic send_sample(input fir16_pkg::sample_type x, input logic st, input logic en);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= x;
      req_ch.block_start <= st;
      req_ch.block_end   <= en;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid, let every expected result arrive, then let the pipeline empty
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input fir16_pkg::csr_index_type idx,
                            input fir16_pkg::csr_word_type value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx < fir16_pkg::COEFF_WORDS) begin
         tap_words[idx] = value;
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic load_taps(input fir16_pkg::csr_word_type w0, input fir16_pkg::csr_word_type w1,
                            input fir16_pkg::csr_word_type w2, input fir16_pkg::csr_word_type w3);
      wait_idle();
      write_csr(COEFF_WORD_0, w0);
      write_csr(COEFF_WORD_1, w1);
      write_csr(COEFF_WORD_2, w2);
      write_csr(COEFF_WORD_3, w3);
   endtask

   function automatic fir16_pkg::sample_type pick_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return fir16_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic fir16_pkg::csr_word_type pick_tap_word();
      fir16_pkg::csr_word_type w;
      for (int s = 0; s < 4; s++) begin
         case ($urandom_range(4))
            0: w[16*s +: 16] = 16'h8000;
            1: w[16*s +: 16] = 16'h7FFF;
            2: w[16*s +: 16] = 16'hFFFF;
            3: w[16*s +: 16] = 16'h0000;
            default: w[16*s +: 16] = 16'($urandom);
         endcase
      end
      return w;
   endfunction

   function automatic fir16_pkg::csr_word_type random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly whole blocks long enough to fill, some short ones, some loose flags
   task automatic run_blocks(input int n_items, input bit with_start);
      int   sent;
      int   len;
      int   pick;
      logic st;
      logic en;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            len = $urandom_range(16, 48);
         end else if (pick < 85) begin
            len = $urandom_range(1, 15);
         end else begin
            len = $urandom_range(1, 8);
         end
         for (int i = 0; i < len && sent < n_items; i++) begin
            if (pick < 85) begin
               st = (i == 0);
               en = (i == len - 1);
            end else begin
               st = ($urandom_range(3) == 0);
               en = ($urandom_range(3) == 0);
            end
            if (!with_start) begin
               st = 1'b0;
            end
            send_sample(pick_sample(), st, en);
            sent++;
         end
      end
   endtask

   // Coefficients still at their reset value; one running stream with no start flag
   task automatic test_reset_coefficients();
      run_blocks(40, 1'b0);
   endtask

   task automatic test_directed_extremes();
      load_taps(TAPS_ALL_MIN, TAPS_ALL_MIN, TAPS_ALL_MIN, TAPS_ALL_MIN);
      // fill with the most negative sample: the end flag on a filling item is dropped
      for (int i = 0; i < fir16_pkg::TAPS; i++) begin
         send_sample(16'sh8000, i == 0, i == 3);
      end
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 1'b0, 1'b1);
      // one-item block with both flags
      send_sample(16'sh0000, 1'b1, 1'b1);
      // restart while still filling
      send_sample(16'sh1234, 1'b0, 1'b0);
      send_sample(16'shFFFF, 1'b1, 1'b0);
      send_sample(16'sh7FFF, 1'b0, 1'b0);
   endtask

   task automatic test_random_coefficients();
      load_taps(random_word(), random_word(), random_word(), random_word());
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_blocks(320, 1'b1);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_max_coefficients();
      load_taps(TAPS_ALL_MAX, TAPS_ALL_MAX, TAPS_ALL_MAX, TAPS_ALL_MAX);
      run_blocks(200, 1'b1);
   endtask

   task automatic test_result_backpressure();
      load_taps(pick_tap_word(), pick_tap_word(), pick_tap_word(), pick_tap_word());
      run_blocks(40, 1'b1);
      hold_request = LONG_HOLD;
      run_blocks(260, 1'b1);
   endtask

   task automatic test_single_tap_impulse();
      fir16_pkg::csr_word_type w [fir16_pkg::COEFF_WORDS];
      int                      k;
      for (int i = 0; i < fir16_pkg::COEFF_WORDS; i++) begin
         w[i] = '0;
      end
      k = $urandom_range(fir16_pkg::TAPS - 1);
      w[k / 4][16 * (k % 4) +: 16] = 16'h7FFF;
      load_taps(w[0], w[1], w[2], w[3]);
      // an index past the coefficient words must leave the taps alone
      write_csr(fir16_pkg::csr_index_type'(fir16_pkg::COEFF_WORDS + $urandom_range(8)),
                random_word());
      run_blocks(200, 1'b1);
   endtask

   task automatic test_all_ones_coefficients();
      load_taps(TAPS_ALL_ONES, TAPS_ALL_ONES, TAPS_ALL_ONES, TAPS_ALL_ONES);
      run_blocks(200, 1'b1);
   endtask

   task automatic test_random_blocks();
      load_taps(random_word(), pick_tap_word(), random_word(), pick_tap_word());
      run_blocks(350, 1'b1);
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.block_start = 1'b0;
      req_ch.block_end   = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      for (int i = 0; i < fir16_pkg::COEFF_WORDS; i++) begin
         tap_words[i] = '0;
      end
      for (int i = 0; i < fir16_pkg::TAPS - 1; i++) begin
         past_samples[i] = '0;
      end
      fill_level     = 0;
      mismatch_count = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      hold_request   = 0;
      hold_left      = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_coefficients();
      test_directed_extremes();
      test_random_coefficients();
      test_max_coefficients();
      test_result_backpressure();
      test_single_tap_impulse();
      test_all_ones_coefficients();
      test_random_blocks();
      wait_idle();

      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/fir16_pkg.sv
src/fir16_ifs.sv
src/fir16_tap_cell.sv
src/fir16_adder_tree.sv
src/fir_filter_16_tap.sv
test/tb_fir_filter_16_tap.sv
